### design/interval_locus_partitioner_assert.svh
`ifndef INTERVAL_LOCUS_PARTITIONER_ASSERT_SVH
`define INTERVAL_LOCUS_PARTITIONER_ASSERT_SVH

// Both macros sample on clk and are disabled while rst_n is low.

// The consequent must hold in the same cycle as the antecedent.
`define ILP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ilp_pkg.sv
`timescale 1ns / 1ps

package ilp_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int PAD_BITS      = 20;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SEQ_START = 3'd0,
        REG_SEQ_END   = 3'd1,
        REG_PAD_DELTA = 3'd2,
        REG_SKIP_ENDS = 3'd3
    } cfg_reg_t;

    localparam logic KIND_LOCUS = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [PAD_BITS-1:0] PAD_RESET = 20'd500;

endpackage

### design/interval_locus_partitioner.sv
`timescale 1ns / 1ps
// An accepted item enters the input register; its first result is loaded into the output
// register when the output can take it, and a second result is held and follows it out.
// Throughput is one item per cycle, with no output stall, for items that give at most one
// result; all results share the single output register, so a held second stalls the input.
// rst_n is asynchronous and active low: it empties the pipeline, drops any pending locus and
// returns the configuration registers to their reset values at once.
`include "interval_locus_partitioner_assert.svh"

module interval_locus_partitioner #(
    parameter int COORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ilp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ilp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [COORD_BITS-1:0]               locus_start,
    input  logic [COORD_BITS-1:0]               locus_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COORD_BITS-1:0]               part_start,
    output logic [COORD_BITS-1:0]               part_end,
    output logic                                has_genes,
    output logic                                last_of_run
);
    import ilp_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int CW = (COORD_BITS > PAD_BITS + 1) ? COORD_BITS : PAD_BITS + 1;
    // Coordinates arrive as 32-bit values even when the datapath is wider.
    localparam logic [W-1:0] IN_MASK = (COORD_BITS > 32) ? W'(64'hFFFF_FFFF) : '1;

    typedef struct packed {
        logic [W-1:0] s;
        logic [W-1:0] e;
        logic         genes;
    } part_t;

    // a > b + d, evaluated without any wrap-around.
    function automatic logic above_sum(logic [W-1:0] a, logic [W-1:0] b,
                                       logic [PAD_BITS:0] d);
        logic [CW-1:0] diff_x;
        logic [CW-1:0] d_x;
        diff_x = CW'(a - b);
        d_x    = CW'(d);
        return (a > b) && (diff_x > d_x);
    endfunction

    // Configuration registers
    logic [W-1:0]          seq_start_reg, seq_start_next;
    logic [W-1:0]          seq_end_reg, seq_end_next;
    logic [PAD_BITS-1:0]   pad_delta_reg, pad_delta_next;
    logic                  skip_ends_reg, skip_ends_next;

    // Sequence state
    logic                  have_pending_reg, have_pending_next;
    logic [W-1:0]          pending_start_reg, pending_start_next;
    logic [W-1:0]          pending_end_reg, pending_end_next;
    logic [W-1:0]          before_end_reg, before_end_next;

    // Input register
    logic                  stage_valid_reg, stage_valid_next;
    logic                  stage_kind_reg;
    logic [W-1:0]          stage_ls_reg;
    logic [W-1:0]          stage_le_reg;

    // Output register and the held second result
    logic                  out_valid_reg, out_valid_next;
    part_t                 out_part_reg, out_part_next;
    logic                  out_last_reg, out_last_next;
    logic                  sec_valid_reg, sec_valid_next;
    part_t                 sec_part_reg, sec_part_next;

    logic                  in_take;
    logic                  cfg_take;
    logic                  out_load;
    logic                  stage_consume;
    logic [1:0]            res_cnt;
    part_t                 res0;
    part_t                 res1;

    logic [W-1:0]          pad_w;
    logic [PAD_BITS:0]     pad_x;
    logic [PAD_BITS:0]     pad_p1;
    logic [W-1:0]          seq_start_m1;
    logic [W-1:0]          ps_val;
    logic [W-1:0]          gap_tail;
    logic [W-1:0]          e_loc;
    logic [W-1:0]          e_flush;
    logic                  flush_fits;
    logic [W-1:0]          cfg_coord;

    assign pad_w        = W'(pad_delta_reg);
    assign pad_x        = {1'b0, pad_delta_reg};
    assign pad_p1       = pad_x + (PAD_BITS+1)'(1);
    assign seq_start_m1 = seq_start_reg - W'(1);
    assign gap_tail     = stage_ls_reg - pad_w - W'(1);
    assign cfg_coord    = W'(cfg_data);

    // Start of the pending part: padded, but never reaching back over the previous locus.
    assign ps_val = above_sum(pending_start_reg, before_end_reg, pad_x)
                    ? (pending_start_reg - pad_w) : (before_end_reg + W'(1));

    assign e_loc = above_sum(stage_ls_reg, pending_end_reg, pad_x)
                   ? (pending_end_reg + pad_w) : (stage_ls_reg - W'(1));

    assign flush_fits = (seq_end_reg >= pending_end_reg)
                        && (CW'(seq_end_reg - pending_end_reg) >= CW'(pad_x));
    assign e_flush    = flush_fits ? (pending_end_reg + pad_w) : seq_end_reg;

    always_comb
    begin
        res_cnt = 2'd0;
        res0    = '0;
        res1    = '0;
        if (stage_kind_reg == KIND_LOCUS)
        begin
            if (!have_pending_reg)
            begin
                res0 = '{s: seq_start_reg, e: gap_tail, genes: 1'b0};
                if (!skip_ends_reg && above_sum(stage_ls_reg, seq_start_reg, pad_x))
                begin
                    res_cnt = 2'd1;
                end
            end
            else
            begin
                res0    = '{s: ps_val, e: e_loc, genes: 1'b1};
                res1    = '{s: e_loc + W'(1), e: gap_tail, genes: 1'b0};
                res_cnt = above_sum(stage_ls_reg, e_loc, pad_p1) ? 2'd2 : 2'd1;
            end
        end
        else
        begin
            if (!have_pending_reg)
            begin
                res0    = '{s: seq_start_reg, e: seq_end_reg, genes: 1'b0};
                res_cnt = 2'd1;
            end
            else
            begin
                res0    = '{s: ps_val, e: e_flush, genes: 1'b1};
                res1    = '{s: e_flush + W'(1), e: seq_end_reg, genes: 1'b0};
                res_cnt = ((e_flush < seq_end_reg) && !skip_ends_reg) ? 2'd2 : 2'd1;
            end
        end
    end

    assign out_load      = !out_valid_reg || !out_stall;
    // A held second result blocks the stage until it has gone out.
    assign stage_consume = stage_valid_reg && !sec_valid_reg
                           && ((res_cnt == 2'd0) || out_load);
    assign in_stall      = stage_valid_reg && !stage_consume;
    assign in_take       = in_valid && !in_stall;
    assign cfg_ready     = 1'b1;
    assign cfg_take      = cfg_valid && cfg_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_part_next  = out_part_reg;
        out_last_next  = out_last_reg;
        sec_valid_next = sec_valid_reg;
        sec_part_next  = sec_part_reg;
        if (out_load)
        begin
            out_valid_next = 1'b0;
            if (sec_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_part_next  = sec_part_reg;
                out_last_next  = 1'b1;
                sec_valid_next = 1'b0;
            end
            else if (stage_consume && (res_cnt != 2'd0))
            begin
                out_valid_next = 1'b1;
                out_part_next  = res0;
                out_last_next  = (res_cnt == 2'd1);
                sec_valid_next = (res_cnt == 2'd2);
                sec_part_next  = res1;
            end
        end
    end

    always_comb
    begin
        stage_valid_next   = stage_valid_reg;
        have_pending_next  = have_pending_reg;
        pending_start_next = pending_start_reg;
        pending_end_next   = pending_end_reg;
        before_end_next    = before_end_reg;
        seq_start_next     = seq_start_reg;
        seq_end_next       = seq_end_reg;
        pad_delta_next     = pad_delta_reg;
        skip_ends_next     = skip_ends_reg;

        if (stage_consume)
        begin
            stage_valid_next = 1'b0;
            if (stage_kind_reg == KIND_LOCUS)
            begin
                before_end_next    = have_pending_reg ? pending_end_reg : seq_start_m1;
                pending_start_next = stage_ls_reg;
                pending_end_next   = stage_le_reg;
                have_pending_next  = 1'b1;
            end
            else
            begin
                before_end_next    = seq_start_m1;
                pending_start_next = '0;
                pending_end_next   = '0;
                have_pending_next  = 1'b0;
            end
        end
        if (in_take)
        begin
            stage_valid_next = 1'b1;
        end

        if (cfg_take)
        begin
            unique case (cfg_index)
                REG_SEQ_START:
                begin
                    seq_start_next = cfg_coord;
                    if (!have_pending_reg)
                    begin
                        before_end_next = cfg_coord - W'(1);
                    end
                end
                REG_SEQ_END:   seq_end_next   = cfg_coord;
                REG_PAD_DELTA: pad_delta_next = cfg_data[PAD_BITS-1:0];
                REG_SKIP_ENDS: skip_ends_next = cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            sec_valid_reg     <= 1'b0;
            have_pending_reg  <= 1'b0;
            pending_start_reg <= '0;
            pending_end_reg   <= '0;
            before_end_reg    <= '0;
            seq_start_reg     <= W'(1);
            seq_end_reg       <= W'(1);
            pad_delta_reg     <= PAD_RESET;
            skip_ends_reg     <= 1'b0;
        end
        else
        begin
            stage_valid_reg   <= stage_valid_next;
            out_valid_reg     <= out_valid_next;
            sec_valid_reg     <= sec_valid_next;
            have_pending_reg  <= have_pending_next;
            pending_start_reg <= pending_start_next;
            pending_end_reg   <= pending_end_next;
            before_end_reg    <= before_end_next;
            seq_start_reg     <= seq_start_next;
            seq_end_reg       <= seq_end_next;
            pad_delta_reg     <= pad_delta_next;
            skip_ends_reg     <= skip_ends_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_kind_reg <= kind;
            stage_ls_reg   <= locus_start & IN_MASK;
            stage_le_reg   <= locus_end & IN_MASK;
        end
        out_part_reg <= out_part_next;
        out_last_reg <= out_last_next;
        sec_part_reg <= sec_part_next;
    end

    assign out_valid   = out_valid_reg;
    assign part_start  = out_part_reg.s;
    assign part_end    = out_part_reg.e;
    assign has_genes   = out_part_reg.genes;
    assign last_of_run = out_last_reg;

    `ILP_ASSERT_NOW(a_sec_behind_out, sec_valid_reg, out_valid_reg,
                    "second result held without a first on show")
    `ILP_ASSERT_NOW(a_sec_is_gap, sec_valid_reg, !sec_part_reg.genes,
                    "held second result is not a gap")
    `ILP_ASSERT_NEXT(a_flush_clears, stage_consume && (stage_kind_reg == KIND_FLUSH),
                     !have_pending_reg, "pending locus survived a flush")
    `ILP_ASSERT_NEXT(a_locus_pends, stage_consume && (stage_kind_reg == KIND_LOCUS),
                     have_pending_reg, "locus was not held as pending")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ilp_pkg::*;

    localparam int CW = 32;
    localparam bit [63:0] CMASK = 64'h0000_0000_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASES = 16;
    localparam int PHASE_ITEMS = 97;
    // An index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE = 3'd5;

    typedef struct packed {
        logic [CW-1:0] p_lo;
        logic [CW-1:0] p_hi;
        logic          genes;
        logic          tail;
    } part_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

    typedef struct packed {
        row_op_t                  op;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [CFG_DATA_BITS-1:0] value;
        logic                     k;
        logic [CW-1:0]            lo;
        logic [CW-1:0]            hi;
        logic                     typed;
        part_t                    want;
    } script_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     kind = KIND_LOCUS;
    logic [CW-1:0]            locus_start = '0;
    logic [CW-1:0]            locus_end = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [CW-1:0]            part_start;
    logic [CW-1:0]            part_end;
    logic                     has_genes;
    logic                     last_of_run;

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int mismatches = 0;

    // Own copy of the block's registers and state.
    bit [63:0] seq_lo = 64'd1;
    bit [63:0] seq_hi = 64'd1;
    bit [19:0] pad = PAD_RESET;
    bit        skip_gaps = 1'b0;
    bit        pend_valid = 1'b0;
    bit [63:0] pend_lo = '0;
    bit [63:0] pend_hi = '0;
    bit [63:0] prev_hi = '0;

    part_t fresh_parts[$];
    part_t parts_due[$];
    script_row_t script[$];

    interval_locus_partitioner #(.COORD_BITS(CW)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .locus_start (locus_start),
        .locus_end   (locus_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .part_start  (part_start),
        .part_end    (part_end),
        .has_genes   (has_genes),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // a > b + d, worked out without overflow
    function automatic bit exceeds(input bit [63:0] a, input bit [63:0] b, input bit [63:0] d);
        return a > b && (a - b) > d;
    endfunction

    function automatic void add_part(input bit [63:0] s, input bit [63:0] e, input bit g);
        part_t p;
        p.p_lo  = s[CW-1:0];
        p.p_hi  = e[CW-1:0];
        p.genes = g;
        p.tail  = 1'b0;
        fresh_parts.push_back(p);
    endfunction

    function automatic bit [63:0] lead_edge();
        if (exceeds(pend_lo, prev_hi, pad))
            return (pend_lo - pad) & CMASK;
        return (prev_hi + 1) & CMASK;
    endfunction

    // Fills fresh_parts with what one item causes and advances the state.
    function automatic void split_locus(input logic k, input logic [CW-1:0] ls_in,
                                        input logic [CW-1:0] le_in);
        bit [63:0] ls;
        bit [63:0] le;
        bit [63:0] s;
        bit [63:0] e;
        ls = ls_in;
        le = le_in;
        fresh_parts.delete();
        if (k == KIND_LOCUS)
        begin
            if (!pend_valid)
            begin
                prev_hi = (seq_lo - 1) & CMASK;
                if (!skip_gaps && exceeds(ls, seq_lo, pad))
                    add_part(seq_lo, ls - pad - 1, 1'b0);
            end
            else
            begin
                s = lead_edge();
                if (ls > pend_hi && (ls - pend_hi) > pad)
                    e = (pend_hi + pad) & CMASK;
                else
                    e = (ls - 1) & CMASK;
                add_part(s, e, 1'b1);
                if (exceeds(ls, e, pad + 1))
                    add_part(e + 1, ls - pad - 1, 1'b0);
                prev_hi = pend_hi;
            end
            pend_lo = ls;
            pend_hi = le;
            pend_valid = 1'b1;
        end
        else
        begin
            if (!pend_valid)
                add_part(seq_lo, seq_hi, 1'b0);
            else
            begin
                s = lead_edge();
                if (seq_hi >= pend_hi && (seq_hi - pend_hi) >= pad)
                    e = (pend_hi + pad) & CMASK;
                else
                    e = seq_hi;
                add_part(s, e, 1'b1);
                if (e < seq_hi && !skip_gaps)
                    add_part(e + 1, seq_hi, 1'b0);
            end
            pend_valid = 1'b0;
            pend_lo = '0;
            pend_hi = '0;
            prev_hi = (seq_lo - 1) & CMASK;
        end
        if (fresh_parts.size() > 0)
            fresh_parts[fresh_parts.size() - 1].tail = 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            REG_SEQ_START:
            begin
                seq_lo = val;
                if (!pend_valid)
                    prev_hi = (seq_lo - 1) & CMASK;
            end
            REG_SEQ_END:   seq_hi = val;
            REG_PAD_DELTA: pad = val[19:0];
            REG_SKIP_ENDS: skip_gaps = val[0];
            default:       ;
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [CW-1:0] want,
                                        input logic [CW-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
        end
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] val);
        script_row_t r;
        r = '0;
        r.op = ROW_CFG;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    function automatic script_row_t item_row(input logic k, input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi);
        script_row_t r;
        r = '0;
        r.op = ROW_ITEM;
        r.k = k;
        r.lo = lo;
        r.hi = hi;
        return r;
    endfunction

    // An item whose single result is written out by hand.
    function automatic script_row_t fixed_row(input logic k, input logic [CW-1:0] ps,
                                              input logic [CW-1:0] pe, input logic g);
        script_row_t r;
        r = item_row(k, '1, '1);
        r.typed = 1'b1;
        r.want = '{p_lo: ps, p_hi: pe, genes: g, tail: 1'b1};
        return r;
    endfunction

    function automatic bit [63:0] gap_pick(input bit [63:0] d, input bit [63:0] span);
        int unsigned wide;
        wide = 32'(4 * d + 100);
        case ($urandom_range(4))
            0:       return $urandom_range(3);
            1:       return (d > 0) ? d - 1 + $urandom_range(2) : $urandom_range(2);
            2:       return 2 * d + $urandom_range(3);
            3:       return $urandom_range(wide);
            default: return {32'd0, $urandom} % (span / 4 + 1);
        endcase
    endfunction

    function automatic bit [63:0] len_pick(input bit [63:0] d);
        int unsigned wide;
        wide = 32'(3 * d + 100);
        case ($urandom_range(2))
            0:       return 0;
            1:       return $urandom_range(50);
            default: return $urandom_range(wide);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        // Valid stays up when another write follows straight away.
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic k, input logic [CW-1:0] lo, input logic [CW-1:0] hi,
                             input bit typed, input part_t want);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        locus_start <= lo;
        locus_end   <= hi;
        do @(posedge clk); while (in_stall);
        split_locus(k, lo, hi);
        if (typed)
            parts_due.push_back(want);
        else
            foreach (fresh_parts[i])
                parts_due.push_back(fresh_parts[i]);
    endtask

    // Items that give no result may still be in flight, so the drain waits on past the last expected result.
    task automatic drain();
        in_valid <= 1'b0;
        while (parts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge clk)
    begin
        part_t due;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (parts_due.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with none expected, expected nothing, got %h %h %b %b",
                         $time, part_start, part_end, has_genes, last_of_run);
            end
            else
            begin
                due = parts_due.pop_front();
                check_field("part_start", due.p_lo, part_start);
                check_field("part_end", due.p_hi, part_end);
                check_field("has_genes", CW'(due.genes), CW'(has_genes));
                check_field("last_of_run", CW'(due.tail), CW'(last_of_run));
            end
        end
    end

    initial
    begin
        int        phase;
        int        sent;
        int        nloci;
        int        j;
        bit [63:0] cursor;
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] span;
        bit [63:0] first;
        bit [63:0] last;
        bit [19:0] pad_w;

        // An empty sequence straight after reset gives the whole range.
        script.push_back(fixed_row(KIND_FLUSH, 32'd1, 32'd1, 1'b0));
        script.push_back(cfg_row(REG_SEQ_START, 32'd1));
        script.push_back(cfg_row(REG_SEQ_END, 32'hFFFF_FFFF));
        script.push_back(cfg_row(REG_PAD_DELTA, 32'd0));
        script.push_back(cfg_row(REG_SKIP_ENDS, 32'd0));
        script.push_back(fixed_row(KIND_FLUSH, 32'd1, 32'hFFFF_FFFF, 1'b0));
        script.push_back(item_row(KIND_LOCUS, 32'd1, 32'hFFFF_FFFF));
        script.push_back(item_row(KIND_FLUSH, 32'h0, 32'h0));
        // Widest padding: leading gap, a neighbour close enough to clip, then a far one.
        script.push_back(cfg_row(REG_SEQ_START, 32'd1000));
        script.push_back(cfg_row(REG_SEQ_END, 32'h0100_0000));
        script.push_back(cfg_row(REG_PAD_DELTA, 32'h000F_FFFF));
        script.push_back(item_row(KIND_LOCUS, 32'h0020_0000, 32'h0020_0100));
        script.push_back(item_row(KIND_LOCUS, 32'h0020_0200, 32'h0020_0300));
        script.push_back(item_row(KIND_LOCUS, 32'h0080_0000, 32'h0080_0010));
        script.push_back(item_row(KIND_FLUSH, 32'h0, 32'h0));
        script.push_back(cfg_row(REG_SKIP_ENDS, 32'd1));
        script.push_back(item_row(KIND_LOCUS, 32'd1500, 32'd1600));
        script.push_back(item_row(KIND_LOCUS, 32'h0040_0000, 32'h0040_0000));
        script.push_back(item_row(KIND_FLUSH, 32'h0, 32'h0));
        script.push_back(item_row(KIND_LOCUS, 32'h00FF_FF00, 32'h0100_0000));
        script.push_back(item_row(KIND_FLUSH, 32'h0, 32'h0));
        // A sequence starting at zero, with a reversed and an out-of-order locus.
        script.push_back(cfg_row(REG_SEQ_START, 32'd0));
        script.push_back(cfg_row(REG_SEQ_END, 32'd100));
        script.push_back(cfg_row(REG_PAD_DELTA, 32'd10));
        script.push_back(cfg_row(REG_SKIP_ENDS, 32'd0));
        script.push_back(item_row(KIND_LOCUS, 32'd5, 32'd20));
        script.push_back(item_row(KIND_LOCUS, 32'd60, 32'd70));
        script.push_back(item_row(KIND_LOCUS, 32'd50, 32'd40));
        script.push_back(item_row(KIND_LOCUS, 32'd10, 32'hFFFF_FFFF));
        script.push_back(item_row(KIND_FLUSH, 32'h0, 32'h0));
        script.push_back(cfg_row(IDX_SPARE, 32'h0000_0007));
        script.push_back(fixed_row(KIND_FLUSH, 32'd0, 32'd100, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[r])
        begin
            if (script[r].op == ROW_CFG)
            begin
                if (r == 0 || script[r-1].op == ROW_ITEM)
                    drain();
                write_reg(script[r].reg_idx, script[r].value,
                          r + 1 < script.size() && script[r+1].op == ROW_CFG);
            end
            else
                send_item(script[r].k, script[r].lo, script[r].hi, script[r].typed,
                          script[r].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case ($urandom_range(3))
                0:       pad_w = '0;
                1:       pad_w = $urandom_range(15);
                2:       pad_w = $urandom_range(3000);
                default: pad_w = $urandom_range(1) ? 20'hF_FFFF : 20'($urandom);
            endcase
            case ($urandom_range(3))
                0:       span = $urandom_range(300);
                1:       span = $urandom_range(200000);
                2:       span = $urandom_range(32'h00FF_FFFF);
                default: span = $urandom;
            endcase
            case ($urandom_range(5))
                0:       first = 0;
                1:       first = 1;
                2:       first = 64'hFFFF_FFFF - span;
                default: first = $urandom_range(32'(64'hFFFF_FFFF - span));
            endcase
            last = first + span;
            // Now and then the sequence end lies before its start.
            if ($urandom_range(7) == 0)
                last = $urandom;
            write_reg(REG_SEQ_START, first[31:0], 1'b1);
            write_reg(REG_SEQ_END, last[31:0], 1'b1);
            write_reg(REG_PAD_DELTA, {12'd0, pad_w}, 1'b1);
            write_reg(REG_SKIP_ENDS, {31'd0, 1'($urandom_range(1))}, 1'b0);

            case (phase % 4)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 65; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 65; end
                default: begin in_idle_pct = 31; out_stall_pct = 31; end
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                nloci = $urandom_range(6);
                cursor = seq_lo;
                for (j = 0; j < nloci; j++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        // A stray locus anywhere in the coordinate space breaks the order.
                        send_item(KIND_LOCUS, $urandom, $urandom, 1'b0, '0);
                        sent++;
                    end
                    lo = cursor + gap_pick(pad, seq_hi - seq_lo);
                    hi = lo + len_pick(pad);
                    if (hi > seq_hi)
                        break;
                    send_item(KIND_LOCUS, lo[31:0], hi[31:0], 1'b0, '0);
                    sent++;
                    cursor = hi + 1;
                end
                // The last sequence of a phase may stay open across the register writes.
                if (sent < PHASE_ITEMS || $urandom_range(1) == 0)
                begin
                    send_item(KIND_FLUSH, $urandom, $urandom, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
